// File: design/section_address_translation_top_assert.svh
// ----------------------------------------------------------------------------
// Section address translation - assertion macros
// Concurrent assertion forms for the controller.
// ----------------------------------------------------------------------------
`ifndef SECTION_ADDRESS_TRANSLATION_TOP_ASSERT_SVH
`define SECTION_ADDRESS_TRANSLATION_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SAT_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SAT_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Types, constants and controller/datapath interface for section translation.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int MAX_SECTIONS = 64;
  localparam int IDX_W        = $clog2(MAX_SECTIONS);
  localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);
  localparam int ADDR_W       = 32;
  localparam int NAME_W       = 64;

  // ".text" followed by a zero byte, little-endian
  localparam logic [47:0] TEXT_NAME = 48'h00_7478_6574_2E;

  // Configuration register indexes
  localparam logic CFG_IMAGE_SIZE    = 1'b0;
  localparam logic CFG_SECTION_COUNT = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_V2F   = 2'd1,
    KIND_F2V   = 2'd2,
    KIND_TEXT  = 2'd3
  } kind_t;

  // One section table row; end bounds and offset delta precomputed at write
  typedef struct packed {
    logic [ADDR_W-1:0] vstart;
    logic [ADDR_W-1:0] vend;
    logic [ADDR_W-1:0] fstart;
    logic [ADDR_W-1:0] fend;
    logic [ADDR_W-1:0] delta;
    logic              text;
  } entry_t;

  typedef struct packed {
    logic             load_in;
    logic             wr_entry;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             take_hit;
    logic             calc_res;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    kind_t            kind;
    logic [CNT_W-1:0] count;
    logic             data_valid;
    logic             stop;
    logic             out_free;
  } status_t;

endpackage

// File: design/section_address_translation_top.sv
// ----------------------------------------------------------------------------
// section_address_translation_top
// Section table with virtual/file address translation and text-section test.
// ----------------------------------------------------------------------------
// Sequence: a table write passes through S_WRITE to S_OUTPUT; a lookup scans
//   entries 0 to n-1 in order in S_SCAN, via S_CALC on a hit, to S_OUTPUT, n being
//   the clamped section count (at most 64). Output stalls hold S_OUTPUT.
// Acceptance: a new transaction is taken once the last result sits in the
//   output register, and not while one is still in progress.
// Reset: rst synchronous, active high; clears config and control state only.
module section_address_translation_top (
  input  logic         clk,
  input  logic         rst,
  // request stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // tuser: [1:0] kind
  input  logic [1:0]   s_tuser,
  // tdata: [5:0] entry_index, [69:6] section_name, [101:70] virtual_address,
  //        [133:102] virtual_size, [165:134] raw_offset, [197:166] raw_length,
  //        [229:198] address, [231:230] zero
  input  logic [231:0] s_tdata,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: [0] ok, [32:1] result_address, [39:33] zero
  output logic [39:0]  m_tdata,
  // configuration write channel: index 0 image_size, 1 section_count
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  sat_pkg::cmd_t    cmd;
  sat_pkg::status_t status;
  sat_pkg::kind_t   kind_in;
  logic             out_ok;
  logic [31:0]      out_result_address;

  assign kind_in   = sat_pkg::kind_t'(s_tuser);
  // config must only arrive while idle (the block does not enforce this); it is always taken at once
  assign cfg_ready = 1'b1;

  sat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (kind_in),
    .in_ready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  sat_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .in_kind            (kind_in),
    .in_entry_index     (s_tdata[5:0]),
    .in_section_name    (s_tdata[69:6]),
    .in_virtual_address (s_tdata[101:70]),
    .in_virtual_size    (s_tdata[133:102]),
    .in_raw_offset      (s_tdata[165:134]),
    .in_raw_length      (s_tdata[197:166]),
    .in_address         (s_tdata[229:198]),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd                (cmd),
    .status             (status),
    .out_ready          (m_tready),
    .out_valid          (m_tvalid),
    .out_ok             (out_ok),
    .out_result_address (out_result_address)
  );

  assign m_tdata = {7'b0, out_result_address, out_ok};

endmodule

// File: design/sat_datapath.sv
// ----------------------------------------------------------------------------
// sat_datapath
// Input latch, section table memory, match test, result and output registers.
// ----------------------------------------------------------------------------
module sat_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  sat_pkg::kind_t                in_kind,
  input  logic [sat_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [sat_pkg::NAME_W-1:0]    in_section_name,
  input  logic [sat_pkg::ADDR_W-1:0]    in_virtual_address,
  input  logic [sat_pkg::ADDR_W-1:0]    in_virtual_size,
  input  logic [sat_pkg::ADDR_W-1:0]    in_raw_offset,
  input  logic [sat_pkg::ADDR_W-1:0]    in_raw_length,
  input  logic [sat_pkg::ADDR_W-1:0]    in_address,
  input  logic                          cfg_valid,
  input  logic                          cfg_index,
  input  logic [sat_pkg::ADDR_W-1:0]    cfg_data,
  input  sat_pkg::cmd_t                 cmd,
  output sat_pkg::status_t              status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_ok,
  output logic [sat_pkg::ADDR_W-1:0]    out_result_address
);

  sat_pkg::kind_t               kind_q;
  logic [sat_pkg::IDX_W-1:0]    idx_q;
  logic [sat_pkg::NAME_W-1:0]   name_q;
  logic [sat_pkg::ADDR_W-1:0]   va_q, vsz_q, ro_q, rl_q, addr_q;

  logic [sat_pkg::ADDR_W-1:0]   image_size;
  logic [sat_pkg::CNT_W-1:0]    section_count;

  sat_pkg::entry_t              table_mem [sat_pkg::MAX_SECTIONS];
  sat_pkg::entry_t              rd_q;
  sat_pkg::entry_t              new_entry;
  logic                         rd_valid;

  logic                         hit_found, hit_span;
  logic [sat_pkg::ADDR_W-1:0]   hit_delta, res_q;
  logic [sat_pkg::ADDR_W-1:0]   span;
  logic                         vspan, fspan;

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_q <= in_kind;
      idx_q  <= in_entry_index;
      name_q <= in_section_name;
      va_q   <= in_virtual_address;
      vsz_q  <= in_virtual_size;
      ro_q   <= in_raw_offset;
      rl_q   <= in_raw_length;
      addr_q <= in_address;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_size    <= '0;
      section_count <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sat_pkg::CFG_IMAGE_SIZE:    image_size    <= cfg_data;
        sat_pkg::CFG_SECTION_COUNT: section_count <= cfg_data[sat_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // row build: span is the larger of the two sizes
  always_comb begin
    span             = (vsz_q > rl_q) ? vsz_q : rl_q;
    new_entry.vstart = va_q;
    new_entry.vend   = va_q + span;
    new_entry.fstart = ro_q;
    new_entry.fend   = ro_q + rl_q;
    new_entry.delta  = ro_q - va_q;
    new_entry.text   = (name_q[47:0] == sat_pkg::TEXT_NAME);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_entry) begin
      table_mem[idx_q] <= new_entry;
    end
    if (cmd.rd_en) begin
      rd_q <= table_mem[cmd.rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
    end
  end

  assign vspan = (addr_q >= rd_q.vstart) && (addr_q < rd_q.vend);
  assign fspan = (addr_q >= rd_q.fstart) && (addr_q < rd_q.fend);

  always_comb begin
    status.kind       = kind_q;
    status.count      = (section_count > sat_pkg::CNT_W'(sat_pkg::MAX_SECTIONS)) ?
                        sat_pkg::CNT_W'(sat_pkg::MAX_SECTIONS) : section_count;
    status.data_valid = rd_valid;
    status.out_free   = !out_valid || out_ready;
    case (kind_q)
      sat_pkg::KIND_V2F:  status.stop = rd_valid && vspan;
      sat_pkg::KIND_F2V:  status.stop = rd_valid && fspan;
      sat_pkg::KIND_TEXT: status.stop = rd_valid && rd_q.text;
      default:            status.stop = 1'b0;
    endcase
  end

  // hit capture and result arithmetic
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found <= 1'b0;
    end else if (cmd.load_in) begin
      hit_found <= 1'b0;
    end else if (cmd.take_hit) begin
      hit_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      hit_delta <= rd_q.delta;
      hit_span  <= fspan;
    end
    if (cmd.calc_res) begin
      case (kind_q)
        sat_pkg::KIND_V2F: res_q <= addr_q + hit_delta;
        sat_pkg::KIND_F2V: res_q <= addr_q - hit_delta;
        default:           res_q <= '0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result_address <= hit_found ? res_q : '0;
      if (kind_q == sat_pkg::KIND_WRITE) begin
        out_ok <= 1'b1;
      end else if (!hit_found) begin
        out_ok <= 1'b0;
      end else begin
        case (kind_q)
          sat_pkg::KIND_V2F: out_ok <= (res_q < image_size);
          sat_pkg::KIND_F2V: out_ok <= 1'b1;
          default:           out_ok <= hit_span;
        endcase
      end
    end
  end

endmodule

// File: design/sat_ctrl.sv
// ----------------------------------------------------------------------------
// sat_ctrl
// Sequencer: accepts a transaction, writes or scans the table, loads output.
// ----------------------------------------------------------------------------
`include "section_address_translation_top_assert.svh"

module sat_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  sat_pkg::kind_t    in_kind,
  output logic              in_ready,
  output sat_pkg::cmd_t     cmd,
  input  sat_pkg::status_t  status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_SCAN,
    S_CALC,
    S_OUTPUT
  } state_t;

  state_t                    state, state_next;
  logic [sat_pkg::CNT_W-1:0] issue_idx, issue_idx_next;
  logic                      issue;

  assign in_ready = (state == S_IDLE);
  assign issue    = (state == S_SCAN) && (issue_idx < status.count);

  always_comb begin
    cmd            = '0;
    cmd.rd_en      = issue;
    cmd.rd_idx     = issue_idx[sat_pkg::IDX_W-1:0];
    state_next     = state;
    issue_idx_next = issue ? issue_idx + sat_pkg::CNT_W'(1) : issue_idx;
    unique case (state)
      S_IDLE: begin
        issue_idx_next = '0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = (in_kind == sat_pkg::KIND_WRITE) ? S_WRITE : S_SCAN;
        end
      end
      S_WRITE: begin
        cmd.wr_entry = 1'b1;
        state_next   = S_OUTPUT;
      end
      S_SCAN: begin
        if (status.stop) begin
          cmd.take_hit = 1'b1;
          state_next   = S_CALC;
        end else if (!issue && !status.data_valid) begin
          state_next = S_OUTPUT;
        end
      end
      S_CALC: begin
        cmd.calc_res = 1'b1;
        state_next   = S_OUTPUT;
      end
      S_OUTPUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issue_idx <= '0;
    end else begin
      state     <= state_next;
      issue_idx <= issue_idx_next;
    end
  end

  `SAT_ASSERT_IMP(a_scan_bound, clk, rst, state == S_SCAN, issue_idx <= status.count, "scan index past count")
  `SAT_ASSERT_NXT(a_hit_then_calc, clk, rst, cmd.take_hit, state == S_CALC, "hit not followed by calc")
  `SAT_ASSERT_IMP(a_write_kind, clk, rst, cmd.wr_entry, status.kind == sat_pkg::KIND_WRITE, "table write on lookup")

endmodule
